FILE: rtl/tfbp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfbp_pkg
// Types and constant tables for the text frame parser.
// ----------------------------------------------------------------------------
package tfbp_pkg;

  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2,
    KIND_REPLY = 2'd3
  } kind_e;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_IDLE = 1'b1
  } op_e;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
  } tfbp_in_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       field_valid;
    logic       frame_status;
    logic       upload_request;
    logic       last;
  } tfbp_out_t;

  // parser -> reply/output stage request
  typedef struct packed {
    logic       valid;
    logic       is_reply;
    logic       ok;
    logic [1:0] kind;
    logic [7:0] data;
    logic       field_valid;
  } tfbp_req_t;

  localparam int unsigned PREFIX_LEN = 5;
  localparam logic [7:0]  PREFIX_BCC = 8'h38;  // XOR of "$X#D#"

  localparam int unsigned REPLY_OK_LEN  = 13;
  localparam int unsigned REPLY_ERR_LEN = 18;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  // "$XA#D#OK&7D\r\n"
  localparam logic [7:0] REPLY_OK [REPLY_OK_LEN] = '{
    8'h24, 8'h58, 8'h41, 8'h23, 8'h44, 8'h23, 8'h4F, 8'h4B,
    8'h26, 8'h37, 8'h44, 8'h0D, 8'h0A
  };

  // "$XA#D#ERR:XOR&43\r\n"
  localparam logic [7:0] REPLY_ERR [REPLY_ERR_LEN] = '{
    8'h24, 8'h58, 8'h41, 8'h23, 8'h44, 8'h23, 8'h45, 8'h52, 8'h52,
    8'h3A, 8'h58, 8'h4F, 8'h52, 8'h26, 8'h34, 8'h33, 8'h0D, 8'h0A
  };

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h58;
      3'd2:    ch = 8'h23;
      3'd3:    ch = 8'h44;
      3'd4:    ch = 8'h23;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 5'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = 5'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = 5'(c - 8'h57);
    end else begin
      v = 5'd16;
    end
    return v;
  endfunction

endpackage

FILE: rtl/tfbp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfbp_parser
// Frame state, prefix hunt, BCC and field split; registers one request.
// ----------------------------------------------------------------------------
module tfbp_parser #(
  parameter int unsigned MAX_BURST = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tfbp_pkg::tfbp_in_t  in_data_i,
  output tfbp_pkg::tfbp_req_t req_o,
  input  logic                req_take_i
);

  localparam int unsigned BW = $clog2(MAX_BURST + 1);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SEG_EMPTY,
    PH_SEG,
    PH_CHK1,
    PH_CHK2
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [2:0]          pidx_q, pidx_d;
  logic [7:0]          bcc_q, bcc_d;
  logic                colon_q, colon_d;
  logic [4:0]          nib_q, nib_d;
  logic [BW-1:0]       burst_q, burst_d;
  tfbp_pkg::tfbp_req_t req_q, req_d;

  logic       accept;
  logic [7:0] c;
  logic [4:0] hv;
  logic [7:0] expected;

  assign in_ready_o = !req_q.valid || req_take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign c          = in_data_i.rx_byte;
  assign hv         = tfbp_pkg::hex_value(c);
  assign req_o      = req_q;

  always_comb begin
    phase_d  = phase_q;
    pidx_d   = pidx_q;
    bcc_d    = bcc_q;
    colon_d  = colon_q;
    nib_d    = nib_q;
    burst_d  = burst_q;
    req_d    = req_q;
    expected = '0;
    if (req_take_i) begin
      req_d.valid = 1'b0;
    end
    if (accept) begin
      req_d = '0;
      if (in_data_i.op == tfbp_pkg::OP_IDLE) begin
        phase_d = PH_HUNT;
        pidx_d  = '0;
        bcc_d   = '0;
        colon_d = 1'b0;
        nib_d   = '0;
        burst_d = '0;
      end else if (burst_q >= BW'(MAX_BURST - 1)) begin
        burst_d = BW'(MAX_BURST);
        phase_d = PH_HUNT;
        pidx_d  = '0;
        bcc_d   = '0;
        colon_d = 1'b0;
        nib_d   = '0;
      end else begin
        burst_d = burst_q + BW'(1);
        unique case (phase_q)
          PH_HUNT: begin
            if (c == tfbp_pkg::prefix_char(pidx_q)) begin
              if (pidx_q == 3'(tfbp_pkg::PREFIX_LEN - 1)) begin
                pidx_d  = '0;
                bcc_d   = tfbp_pkg::PREFIX_BCC;
                colon_d = 1'b0;
                phase_d = PH_SEG_EMPTY;
              end else begin
                pidx_d = pidx_q + 3'd1;
              end
            end else begin
              pidx_d = (c == tfbp_pkg::CH_DOLLAR) ? 3'd1 : 3'd0;
            end
          end
          PH_SEG_EMPTY, PH_SEG: begin
            if (c == tfbp_pkg::CH_AMP) begin
              req_d.valid       = (phase_q == PH_SEG);
              req_d.kind        = tfbp_pkg::KIND_END;
              req_d.field_valid = colon_q;
              colon_d           = 1'b0;
              phase_d           = PH_CHK1;
            end else begin
              bcc_d = bcc_q ^ c;
              if (c == tfbp_pkg::CH_SEMI) begin
                req_d.valid       = (phase_q == PH_SEG);
                req_d.kind        = tfbp_pkg::KIND_END;
                req_d.field_valid = colon_q;
                colon_d           = 1'b0;
                phase_d           = PH_SEG_EMPTY;
              end else if (c == tfbp_pkg::CH_COLON && !colon_q) begin
                colon_d = 1'b1;
                phase_d = PH_SEG;
              end else begin
                req_d.valid = 1'b1;
                req_d.kind  = colon_q ? tfbp_pkg::KIND_VALUE : tfbp_pkg::KIND_KEY;
                req_d.data  = c;
                phase_d     = PH_SEG;
              end
            end
          end
          PH_CHK1: begin
            nib_d   = hv;
            phase_d = PH_CHK2;
          end
          PH_CHK2: begin
            if (nib_q[4]) begin
              expected = '0;
            end else if (hv[4]) begin
              expected = {4'd0, nib_q[3:0]};
            end else begin
              expected = {nib_q[3:0], hv[3:0]};
            end
            req_d.valid    = 1'b1;
            req_d.is_reply = 1'b1;
            req_d.kind     = tfbp_pkg::KIND_REPLY;
            req_d.ok       = (expected == bcc_q);
            phase_d        = PH_HUNT;
            pidx_d         = '0;
            bcc_d          = '0;
            colon_d        = 1'b0;
            nib_d          = '0;
          end
          default: begin
            phase_d = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pidx_q  <= '0;
      bcc_q   <= '0;
      colon_q <= 1'b0;
      nib_q   <= '0;
      burst_q <= '0;
      req_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pidx_q  <= pidx_d;
      bcc_q   <= bcc_d;
      colon_q <= colon_d;
      nib_q   <= nib_d;
      burst_q <= burst_d;
      req_q   <= req_d;
    end
  end

  a_burst_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q <= BW'(MAX_BURST))
    else $error("burst count out of range");

  a_hold_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_q.valid && !req_take_i |=> req_q.valid && $stable(req_q.kind) && $stable(req_q.data))
    else $error("pending request changed before it was taken");

endmodule

FILE: rtl/tfbp_emitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfbp_emitter
// Output register; expands a reply request into its byte sequence.
// ----------------------------------------------------------------------------
module tfbp_emitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tfbp_pkg::tfbp_req_t req_i,
  output logic                req_take_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tfbp_pkg::tfbp_out_t out_data_o
);

  localparam int unsigned IW = $clog2(tfbp_pkg::REPLY_ERR_LEN);

  logic                out_valid_q, out_valid_d;
  tfbp_pkg::tfbp_out_t out_q, out_d;
  logic                busy_q, busy_d;
  logic                ok_q, ok_d;
  logic [IW-1:0]       idx_q, idx_d;

  logic          out_free;
  logic          sel_ok;
  logic [IW-1:0] sel_idx;
  logic [IW-1:0] sel_end;
  logic [7:0]    sel_char;

  assign out_free   = !out_valid_q || out_ready_i;
  assign req_take_o = out_free && !busy_q && req_i.valid;
  assign sel_ok     = busy_q ? ok_q : req_i.ok;
  assign sel_idx    = busy_q ? idx_q : '0;
  assign sel_end    = sel_ok ? IW'(tfbp_pkg::REPLY_OK_LEN - 1)
                             : IW'(tfbp_pkg::REPLY_ERR_LEN - 1);
  assign sel_char   = sel_ok ? tfbp_pkg::REPLY_OK[sel_idx[3:0]]
                             : tfbp_pkg::REPLY_ERR[sel_idx];

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    busy_d      = busy_q;
    ok_d        = ok_q;
    idx_d       = idx_q;
    if (out_free) begin
      out_valid_d = 1'b0;
      if (busy_q || (req_i.valid && req_i.is_reply)) begin
        out_valid_d          = 1'b1;
        out_d.out_kind       = tfbp_pkg::KIND_REPLY;
        out_d.out_byte       = sel_char;
        out_d.field_valid    = 1'b0;
        out_d.frame_status   = !sel_ok;
        out_d.last           = (sel_idx == sel_end);
        out_d.upload_request = sel_ok && (sel_idx == sel_end);
        ok_d                 = sel_ok;
        busy_d               = (sel_idx != sel_end);
        idx_d                = sel_idx + IW'(1);
      end else if (req_i.valid) begin
        out_valid_d          = 1'b1;
        out_d.out_kind       = req_i.kind;
        out_d.out_byte       = req_i.data;
        out_d.field_valid    = req_i.field_valid;
        out_d.frame_status   = 1'b0;
        out_d.upload_request = 1'b0;
        out_d.last           = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      busy_q      <= 1'b0;
      ok_q        <= 1'b0;
      idx_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      busy_q      <= busy_d;
      ok_q        <= ok_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_busy_has_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> out_valid_q && !out_q.last)
    else $error("reply in progress without a pending byte");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q < IW'(tfbp_pkg::REPLY_ERR_LEN))
    else $error("reply index out of range");

  a_upload_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.upload_request |-> out_q.last && !out_q.frame_status)
    else $error("upload request outside the end of an OK reply");

endmodule

FILE: rtl/text_frame_bcc_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_frame_bcc_parser
// ASCII frame parser with XOR block check and reply generation.
// ----------------------------------------------------------------------------
// Takes one byte or idle event per cycle unless stalled. Key, value and
// field-end results pass through the parse register, then the output
// register. A checked frame produces a reply of 13 bytes (OK) or 18 bytes
// (ERR), driven at one byte per cycle from the output register while
// out_ready_i is high; during that time the parse register fills and input
// is held after one more request. Input stalls only while the parse
// register holds a request that the output side cannot take yet. Byte
// number MAX_BURST of a burst and every byte after it until line idle are dropped along with the partial frame.
module text_frame_bcc_parser #(
  parameter int unsigned MAX_BURST = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tfbp_pkg::tfbp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tfbp_pkg::tfbp_out_t out_data_o
);

  tfbp_pkg::tfbp_req_t req;
  logic                req_take;

  tfbp_parser #(
    .MAX_BURST (MAX_BURST)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .req_o      (req),
    .req_take_i (req_take)
  );

  tfbp_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req),
    .req_take_o  (req_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
